/* design/thc_pkg.sv */
// shared constants and register indexes for the terraced height composer
package thc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_HEIGHT_SCALE   = 3'd0,
        CFG_RIDGE_GAIN     = 3'd1,
        CFG_LAKE_THRESHOLD = 3'd2,
        CFG_BASIN_DEPTH    = 3'd3,
        CFG_TERRACE_STEP   = 3'd4,
        CFG_VARIATION_AMPS = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SAMPLE_W   = 16;
    localparam int METER_W    = 20;
    localparam int AMP_W      = 16;
    localparam int HEIGHT_W   = 32;

    // working width of relief in signed Q.24 meters
    localparam int RELIEF_W   = 44;

    // lowness divider: ((T - e) << 16) / T
    localparam int LOW_NUM_W  = 33;
    // terrace divider: ((2|r| + s) >> 17) / step
    localparam int TER_NUM_W  = 28;

    localparam logic [SAMPLE_W:0] HALF_SAMPLE = 17'd32768;
    localparam logic [16:0]       LOW_ONE     = 17'd65536;

endpackage

/* design/thc_div_cell.sv */
// one restoring division cell: resolves one quotient bit per cycle
module thc_div_cell #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_quo,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_num,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [PW-1:0] o_pay
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        diff  = trial - {1'b0, i_den};
        ge    = (trial >= {1'b0, i_den});
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // data hand-off to the next cell
    always_ff @(posedge i_clk) begin
        o_num <= {i_num[NW-2:0], 1'b0};
        o_quo <= {i_quo[NW-2:0], ge};
        o_rem <= n_rem;
        o_den <= i_den;
        o_pay <= i_pay;
    end

endmodule

/* design/thc_divider.sv */
// pipelined restoring divider built as a row of division cells
module thc_divider #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic          c_valid [0:NW];
    logic [NW-1:0] c_num   [0:NW];
    logic [NW-1:0] c_quo   [0:NW];
    logic [DW-1:0] c_rem   [0:NW];
    logic [DW-1:0] c_den   [0:NW];
    logic [PW-1:0] c_pay   [0:NW];

    // chain head
    assign c_valid[0] = i_valid;
    assign c_num[0]   = i_num;
    assign c_quo[0]   = '0;
    assign c_rem[0]   = '0;
    assign c_den[0]   = i_den;
    assign c_pay[0]   = i_pay;

    // one cell per quotient bit
    for (genvar k = 0; k < NW; k++) begin : g_cell
        thc_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_num   (c_num[k]),
            .i_quo   (c_quo[k]),
            .i_rem   (c_rem[k]),
            .i_den   (c_den[k]),
            .i_pay   (c_pay[k]),
            .o_valid (c_valid[k+1]),
            .o_num   (c_num[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_den   (c_den[k+1]),
            .o_pay   (c_pay[k+1])
        );
    end

    assign o_valid = c_valid[NW];
    assign o_quo   = c_quo[NW];
    assign o_pay   = c_pay[NW];

endmodule

/* design/terraced_height_composer.sv */
// terraced height composer: per-pixel terrain height pipeline
// pipeline from accepting start to the o_valid strobe: 33 lowness divider cells,
//   28 terrace divider cells and 11 arithmetic stages
// throughput: one pixel per cycle; busy is never raised
// reset: synchronous active-low clears the pipeline valids and all config registers
// results are strobed for one cycle on o_valid; the receiver cannot stall
module terraced_height_composer #(
    parameter int NUM_BIOMES = 4,
    parameter int HILLS_CODE = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [thc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [thc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_biome_code,
    input  logic [thc_pkg::SAMPLE_W-1:0]   i_elevation_sample,
    input  logic [thc_pkg::SAMPLE_W-1:0]   i_ridged_sample,
    input  logic [thc_pkg::SAMPLE_W-1:0]   i_fine_sample,
    output logic                           o_valid,
    output logic signed [thc_pkg::HEIGHT_W-1:0] o_height_out
);

    localparam int SW  = thc_pkg::SAMPLE_W;
    localparam int MW  = thc_pkg::METER_W;
    localparam int RW  = thc_pkg::RELIEF_W;
    localparam int LNW = thc_pkg::LOW_NUM_W;
    localparam int TNW = thc_pkg::TER_NUM_W;
    localparam int APW = 2 + 3 * SW;
    localparam int VW  = SW + 1 + thc_pkg::AMP_W;
    localparam int BPW = 1 + RW + VW;
    localparam int RNW = RW - 15;
    localparam int LAT = LNW + TNW + 11;

    // configuration registers
    logic [MW-1:0] r_height_scale;
    logic [MW-1:0] r_ridge_gain;
    logic [SW-1:0] r_lake_threshold;
    logic [MW-1:0] r_basin_depth;
    logic [MW-1:0] r_terrace_step;
    logic [thc_pkg::CFG_DATA_W-1:0] r_variation_amps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_scale   <= '0;
            r_ridge_gain     <= '0;
            r_lake_threshold <= '0;
            r_basin_depth    <= '0;
            r_terrace_step   <= '0;
            r_variation_amps <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                thc_pkg::CFG_HEIGHT_SCALE:   r_height_scale   <= i_cfg_data[MW-1:0];
                thc_pkg::CFG_RIDGE_GAIN:     r_ridge_gain     <= i_cfg_data[MW-1:0];
                thc_pkg::CFG_LAKE_THRESHOLD: r_lake_threshold <= i_cfg_data[SW-1:0];
                thc_pkg::CFG_BASIN_DEPTH:    r_basin_depth    <= i_cfg_data[MW-1:0];
                thc_pkg::CFG_TERRACE_STEP:   r_terrace_step   <= i_cfg_data[MW-1:0];
                thc_pkg::CFG_VARIATION_AMPS: r_variation_amps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // lowness divider operands; a disabled basin divides zero by one
    logic          low_on;
    logic [LNW-1:0] low_num;
    logic [SW-1:0]  low_den;
    logic [SW-1:0]  low_diff;

    always_comb begin
        low_on   = (r_lake_threshold != '0) && (i_elevation_sample < r_lake_threshold);
        low_diff = r_lake_threshold - i_elevation_sample;
        low_num  = low_on ? {1'b0, low_diff, 16'b0} : '0;
        low_den  = (r_lake_threshold != '0) ? r_lake_threshold : SW'(1);
    end

    logic           la_valid;
    logic [LNW-1:0] la_quo;
    logic [APW-1:0] la_pay;

    thc_divider #(.NW(LNW), .DW(SW), .PW(APW)) u_low_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_num   (low_num),
        .i_den   (low_den),
        .i_pay   ({i_biome_code, i_elevation_sample, i_ridged_sample, i_fine_sample}),
        .o_valid (la_valid),
        .o_quo   (la_quo),
        .o_pay   (la_pay)
    );

    logic [1:0]    la_biome;
    logic [SW-1:0] la_e;
    logic [SW-1:0] la_r;
    logic [SW-1:0] la_f;
    logic [thc_pkg::AMP_W-1:0] la_amp;
    assign {la_biome, la_e, la_r, la_f} = la_pay;

    // biome amplitude lookup
    always_comb begin
        if (32'(la_biome) < NUM_BIOMES) begin
            la_amp = r_variation_amps[{la_biome, 4'b0} +: thc_pkg::AMP_W];
        end else begin
            la_amp = '0;
        end
    end

    // stage 1: products of samples and smoothstep first factors
    logic                 r_s1_valid;
    logic [32:0]          r_s1_tt;
    logic [17:0]          r_s1_w;
    logic [SW+MW-1:0]     r_s1_pe;
    logic signed [SW+MW:0] r_s1_pr;
    logic signed [VW-1:0] r_s1_var;
    logic                 r_s1_hills;
    logic [16:0]          t17;
    logic signed [SW:0]   rs_c;
    logic signed [SW:0]   fs_c;

    always_comb begin
        t17  = la_quo[16:0];
        rs_c = $signed({1'b0, la_r}) - $signed(thc_pkg::HALF_SAMPLE);
        fs_c = $signed({1'b0, la_f}) - $signed(thc_pkg::HALF_SAMPLE);
    end

    always_ff @(posedge i_clk) begin
        r_s1_tt    <= 33'({16'b0, t17} * {16'b0, t17});
        r_s1_w     <= 18'(3 * 65536) - {t17, 1'b0};
        r_s1_pe    <= {{MW{1'b0}}, la_e} * {{SW{1'b0}}, r_height_scale};
        r_s1_pr    <= (SW+MW+1)'(rs_c) * (SW+MW+1)'($signed({1'b0, r_ridge_gain}));
        r_s1_var   <= VW'(fs_c) * VW'($signed({1'b0, la_amp}));
        r_s1_hills <= (32'(la_biome) == HILLS_CODE);
    end

    // stage 2: smoothstep product and partial relief
    logic                 r_s2_valid;
    logic [50:0]          r_s2_p;
    logic signed [RW-1:0] r_s2_rel;
    logic signed [VW-1:0] r_s2_var;

    always_ff @(posedge i_clk) begin
        r_s2_p   <= {18'b0, r_s1_tt} * {33'b0, r_s1_w};
        r_s2_rel <= $signed({{(RW-SW-MW){1'b0}}, r_s1_pe})
                  + (r_s1_hills ? RW'(r_s1_pr) : RW'(0));
        r_s2_var <= r_s1_var;
    end

    // stage 3: round lowness to Q1.16
    logic                 r_s3_valid;
    logic [16:0]          r_s3_low;
    logic signed [RW-1:0] r_s3_rel;
    logic signed [VW-1:0] r_s3_var;
    logic [51:0]          low_sum;

    assign low_sum = {1'b0, r_s2_p} + 52'h0_0000_8000_0000;

    always_ff @(posedge i_clk) begin
        r_s3_low <= low_sum[48:32];
        r_s3_rel <= r_s2_rel;
        r_s3_var <= r_s2_var;
    end

    // stage 4: basin depth
    logic                 r_s4_valid;
    logic [MW+16:0]       r_s4_bas;
    logic signed [RW-1:0] r_s4_rel;
    logic signed [VW-1:0] r_s4_var;

    always_ff @(posedge i_clk) begin
        r_s4_bas <= {17'b0, r_basin_depth} * {{MW{1'b0}}, r_s3_low};
        r_s4_rel <= r_s3_rel;
        r_s4_var <= r_s3_var;
    end

    // stage 5: subtract the basin
    logic                 r_s5_valid;
    logic signed [RW-1:0] r_s5_rel;
    logic signed [VW-1:0] r_s5_var;

    always_ff @(posedge i_clk) begin
        r_s5_rel <= r_s4_rel - $signed({{(RW-MW-17){1'b0}}, r_s4_bas});
        r_s5_var <= r_s4_var;
    end

    // stage 6: magnitude and terrace dividend
    logic                 r_s6_valid;
    logic [TNW-1:0]       r_s6_num;
    logic                 r_s6_neg;
    logic signed [RW-1:0] r_s6_rel;
    logic signed [VW-1:0] r_s6_var;
    logic [RW-1:0]        mag5;
    logic [RW+1:0]        ter_sum;

    always_comb begin
        mag5    = r_s5_rel[RW-1] ? RW'(-r_s5_rel) : RW'(r_s5_rel);
        ter_sum = {1'b0, mag5, 1'b0} + {{(RW+2-MW-16){1'b0}}, r_terrace_step, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        r_s6_num <= ter_sum[17 +: TNW];
        r_s6_neg <= r_s5_rel[RW-1];
        r_s6_rel <= r_s5_rel;
        r_s6_var <= r_s5_var;
    end

    // terrace divider; a zero step divides by one and is bypassed after
    logic           tb_valid;
    logic [TNW-1:0] tb_quo;
    logic [BPW-1:0] tb_pay;
    logic [MW-1:0]  ter_den;

    assign ter_den = (r_terrace_step != '0) ? r_terrace_step : MW'(1);

    thc_divider #(.NW(TNW), .DW(MW), .PW(BPW)) u_ter_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_valid),
        .i_num   (r_s6_num),
        .i_den   (ter_den),
        .i_pay   ({r_s6_neg, r_s6_rel, r_s6_var}),
        .o_valid (tb_valid),
        .o_quo   (tb_quo),
        .o_pay   (tb_pay)
    );

    logic                 tb_neg;
    logic signed [RW-1:0] tb_rel;
    logic signed [VW-1:0] tb_var;
    assign {tb_neg, tb_rel, tb_var} = tb_pay;

    // stage 7: quotient times step
    logic                 r_s7_valid;
    logic [TNW+MW-1:0]    r_s7_qs;
    logic                 r_s7_neg;
    logic signed [RW-1:0] r_s7_rel;
    logic signed [VW-1:0] r_s7_var;

    always_ff @(posedge i_clk) begin
        r_s7_qs  <= {{MW{1'b0}}, tb_quo} * {{TNW{1'b0}}, r_terrace_step};
        r_s7_neg <= tb_neg;
        r_s7_rel <= tb_rel;
        r_s7_var <= tb_var;
    end

    // stage 8: terraced relief with sign restored
    logic                 r_s8_valid;
    logic signed [RW-1:0] r_s8_rel;
    logic signed [VW-1:0] r_s8_var;
    logic [RW-1:0]        ter_mag;

    assign ter_mag = {r_s7_qs[RW-17:0], 16'b0};

    always_ff @(posedge i_clk) begin
        if (r_terrace_step == '0) begin
            r_s8_rel <= r_s7_rel;
        end else begin
            r_s8_rel <= r_s7_neg ? -$signed(ter_mag) : $signed(ter_mag);
        end
        r_s8_var <= r_s7_var;
    end

    // stage 9: add biome variation
    logic                 r_s9_valid;
    logic signed [RW-1:0] r_s9_sum;

    always_ff @(posedge i_clk) begin
        r_s9_sum <= r_s8_rel + RW'(r_s8_var);
    end

    // stage 10: round magnitude from Q.24 to Q.8
    logic           r_s10_valid;
    logic [RNW-1:0] r_s10_rnd;
    logic           r_s10_neg;
    logic [RW-1:0]  mag9;
    logic [RW:0]    rnd_sum;

    always_comb begin
        mag9    = r_s9_sum[RW-1] ? RW'(-r_s9_sum) : RW'(r_s9_sum);
        rnd_sum = {1'b0, mag9} + (RW+1)'(32768);
    end

    always_ff @(posedge i_clk) begin
        r_s10_rnd <= rnd_sum[RW:16];
        r_s10_neg <= r_s9_sum[RW-1];
    end

    // stage 11: sign and saturate to the output register
    logic [32:0] rnd_ext;
    assign rnd_ext = 33'(r_s10_rnd);

    always_ff @(posedge i_clk) begin
        if (!r_s10_neg && (rnd_ext > 33'h0_7FFF_FFFF)) begin
            o_height_out <= 32'sh7FFF_FFFF;
        end else if (r_s10_neg && (rnd_ext > 33'h0_8000_0000)) begin
            o_height_out <= 32'sh8000_0000;
        end else if (r_s10_neg) begin
            o_height_out <= 32'(-$signed(rnd_ext));
        end else begin
            o_height_out <= 32'(rnd_ext);
        end
    end

    // stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_s9_valid  <= 1'b0;
            r_s10_valid <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_s1_valid  <= la_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= tb_valid;
            r_s8_valid  <= r_s7_valid;
            r_s9_valid  <= r_s8_valid;
            r_s10_valid <= r_s9_valid;
            o_valid     <= r_s10_valid;
        end
    end

    // every accepted transaction comes out on o_valid once it has passed both dividers and all arithmetic stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("result strobe missing after fixed latency");

    // smoothstep lowness never exceeds one
    a_low_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_s3_low <= thc_pkg::LOW_ONE) || !$past(r_s3_valid))
        else $error("lowness out of range");

    // no strobe in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("strobe after reset");

    // a zero terrace step leaves relief untouched
    a_no_terrace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s7_valid && r_terrace_step == '0 && !i_cfg_we) |=> (r_s8_rel == $past(r_s7_rel)))
        else $error("relief changed with terracing off");

endmodule
